FILE: hdl/sbems_pkg.sv
package sbems_pkg;

  localparam logic [1:0] MODE_PUSH = 2'd0;
  localparam logic [1:0] MODE_POP  = 2'd1;
  localparam logic [1:0] MODE_PEEK = 2'd2;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0]         mode;
    logic [1:0]         stack_sel;
    logic signed [31:0] push_value;
  } sbems_in_t;

  typedef struct packed {
    logic signed [31:0] read_value;
    logic [1:0]         status;
  } sbems_out_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_RDWAIT,
    S_PUSH,
    S_SCAN,
    S_MVSET,
    S_MVRD,
    S_MVWR,
    S_MVZERO,
    S_GROWFIN,
    S_DONE
  } sbems_state_t;

endpackage

FILE: hdl/sbems_ram.sv
module sbems_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 24
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: hdl/shared_buffer_elastic_multi_stack.sv
// Pop, peek and plain push take a word-store access; empty, full and ignored requests
// return a status straight from decode. A push into a full stack first scans in ring
// order for a stack with room, shifts every stack from that donor back towards the
// selected one up by one slot, then grows the selected stack and pushes. One item at a
// time; the next is accepted only once the result is registered. Reset (rst_n low,
// synchronous) restores the equal regions, then clears the whole word store.
module shared_buffer_elastic_multi_stack
  import sbems_pkg::*;
#(
  parameter int NUM_STACKS    = 3,
  parameter int INIT_CAPACITY = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  sbems_in_t  in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output sbems_out_t out_data
);

  localparam int DEPTH = NUM_STACKS * INIT_CAPACITY;
  localparam int AW    = $clog2(DEPTH);       // word address
  localparam int CW    = $clog2(DEPTH + 1);   // fill / capacity count
  localparam int PW    = $clog2(NUM_STACKS);  // stack pointer

  // Add an offset to a ring address; the sum always stays below 2*DEPTH.
  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a,
                                             input logic [CW-1:0] b);
    logic [CW:0] s;
    s = (CW+1)'(a) + (CW+1)'(b);
    if (s >= (CW+1)'(DEPTH)) begin
      s = s - (CW+1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  sbems_state_t state_r, state_nxt;

  // Per-stack bookkeeping, indexed through ptr_r outside reset.
  logic [AW-1:0] start_r [NUM_STACKS];
  logic [CW-1:0] fill_r  [NUM_STACKS];
  logic [CW-1:0] cap_r   [NUM_STACKS];
  logic [AW-1:0] start_nxt;
  logic [CW-1:0] fill_nxt, cap_nxt;
  logic          start_we, fill_we, cap_we;

  logic [CW-1:0] total_r, total_nxt;   // words held over all stacks
  logic [PW-1:0] ptr_r, ptr_nxt;       // stack being worked on
  logic [AW-1:0] clr_r, clr_nxt;       // clearing pass address
  logic [AW-1:0] base_r, base_nxt;     // start of the region being shifted
  logic [CW-1:0] idx_r, idx_nxt;       // destination offset of the next copy
  logic          first_r, first_nxt;   // shifting the donor stack

  logic [1:0]         mode_r, mode_nxt;
  logic [1:0]         sel_r, sel_nxt;
  logic [31:0]        val_r, val_nxt;
  logic [31:0]        res_val_r, res_val_nxt;
  logic [1:0]         res_st_r, res_st_nxt;
  logic               out_valid_r, out_valid_nxt;
  sbems_out_t         out_data_r, out_data_nxt;

  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [31:0]   ram_wdata, ram_rdata;

  logic [PW-1:0] ptr_inc, ptr_dec;
  logic          sel_ok;
  logic          cur_full;

  sbems_ram #(
    .WIDTH(32),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign ptr_inc  = (ptr_r == PW'(NUM_STACKS - 1)) ? '0 : ptr_r + PW'(1);
  assign ptr_dec  = (ptr_r == '0) ? PW'(NUM_STACKS - 1) : ptr_r - PW'(1);
  assign sel_ok   = 32'(sel_r) < NUM_STACKS;
  assign cur_full = fill_r[ptr_r] >= cap_r[ptr_r];

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    start_nxt     = start_r[ptr_r];
    fill_nxt      = fill_r[ptr_r];
    cap_nxt       = cap_r[ptr_r];
    start_we      = 1'b0;
    fill_we       = 1'b0;
    cap_we        = 1'b0;
    total_nxt     = total_r;
    ptr_nxt       = ptr_r;
    clr_nxt       = clr_r;
    base_nxt      = base_r;
    idx_nxt       = idx_r;
    first_nxt     = first_r;
    mode_nxt      = mode_r;
    sel_nxt       = sel_r;
    val_nxt       = val_r;
    res_val_nxt   = res_val_r;
    res_st_nxt    = res_st_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = '0;
    ram_raddr     = '0;

    // Drop the result once the consumer takes it.
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_CLEAR: begin
        // Zero the whole word store, one word per cycle.
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        clr_nxt   = clr_r + AW'(1);
        if (clr_r == AW'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          mode_nxt    = in_data.mode;
          sel_nxt     = in_data.stack_sel;
          val_nxt     = in_data.push_value;
          ptr_nxt     = PW'(in_data.stack_sel);
          res_val_nxt = '0;
          res_st_nxt  = STAT_OK;
          state_nxt   = S_DECODE;
        end
      end
      S_DECODE: begin
        state_nxt = S_DONE;
        if (sel_ok) begin
          priority if (mode_r == MODE_PUSH) begin
            if (total_r >= CW'(DEPTH)) begin
              res_st_nxt = STAT_FULL;
            end else if (cur_full) begin
              // Look for the next stack in ring order with spare room.
              ptr_nxt   = ptr_inc;
              first_nxt = 1'b1;
              state_nxt = S_SCAN;
            end else begin
              state_nxt = S_PUSH;
            end
          end else if (mode_r == MODE_POP || mode_r == MODE_PEEK) begin
            if (fill_r[ptr_r] == '0) begin
              res_st_nxt = STAT_EMPTY;
            end else begin
              ram_raddr = wrap_add(start_r[ptr_r], fill_r[ptr_r] - CW'(1));
              state_nxt = S_RDWAIT;
            end
          end else begin
            res_st_nxt = STAT_OK;
          end
        end
      end
      S_RDWAIT: begin
        res_val_nxt = ram_rdata;
        if (mode_r == MODE_POP) begin
          ram_we    = 1'b1;
          ram_waddr = wrap_add(start_r[ptr_r], fill_r[ptr_r] - CW'(1));
          fill_nxt  = fill_r[ptr_r] - CW'(1);
          fill_we   = 1'b1;
          total_nxt = total_r - CW'(1);
        end
        state_nxt = S_DONE;
      end
      S_PUSH: begin
        // New top sits just above the old one.
        ram_we    = 1'b1;
        ram_waddr = wrap_add(start_r[ptr_r], fill_r[ptr_r]);
        ram_wdata = val_r;
        fill_nxt  = fill_r[ptr_r] + CW'(1);
        fill_we   = 1'b1;
        total_nxt = total_r + CW'(1);
        state_nxt = S_DONE;
      end
      S_SCAN: begin
        if (cur_full) begin
          ptr_nxt = ptr_inc;
        end else begin
          state_nxt = S_MVSET;
        end
      end
      S_MVSET: begin
        // Donor moves one word less than its capacity; a full stack in between moves its whole capacity.
        base_nxt = start_r[ptr_r];
        idx_nxt  = first_r ? cap_r[ptr_r] - CW'(1) : cap_r[ptr_r];
        if ((first_r && cap_r[ptr_r] == CW'(1)) || (!first_r && cap_r[ptr_r] == '0)) begin
          state_nxt = S_MVZERO;
        end else begin
          state_nxt = S_MVRD;
        end
      end
      S_MVRD: begin
        ram_raddr = wrap_add(base_r, idx_r - CW'(1));
        state_nxt = S_MVWR;
      end
      S_MVWR: begin
        ram_we    = 1'b1;
        ram_waddr = wrap_add(base_r, idx_r);
        ram_wdata = ram_rdata;
        idx_nxt   = idx_r - CW'(1);
        state_nxt = (idx_r == CW'(1)) ? S_MVZERO : S_MVRD;
      end
      S_MVZERO: begin
        // Vacate the bottom slot and advance the region start.
        ram_we    = 1'b1;
        ram_waddr = base_r;
        start_nxt = wrap_add(base_r, CW'(1));
        start_we  = 1'b1;
        if (first_r) begin
          cap_nxt = cap_r[ptr_r] - CW'(1);
          cap_we  = 1'b1;
        end
        first_nxt = 1'b0;
        ptr_nxt   = ptr_dec;
        state_nxt = (ptr_dec == PW'(sel_r)) ? S_GROWFIN : S_MVSET;
      end
      S_GROWFIN: begin
        cap_nxt   = cap_r[ptr_r] + CW'(1);
        cap_we    = 1'b1;
        state_nxt = S_PUSH;
      end
      S_DONE: begin
        // Hold the result until the output register is free.
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt           = 1'b1;
          out_data_nxt.read_value = res_val_r;
          out_data_nxt.status     = res_st_r;
          state_nxt               = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      total_r     <= '0;
      ptr_r       <= '0;
      first_r     <= 1'b0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < NUM_STACKS; k++) begin
        start_r[k] <= AW'(k * INIT_CAPACITY);
        fill_r[k]  <= '0;
        cap_r[k]   <= CW'(INIT_CAPACITY);
      end
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      total_r     <= total_nxt;
      ptr_r       <= ptr_nxt;
      first_r     <= first_nxt;
      out_valid_r <= out_valid_nxt;
      if (start_we) begin
        start_r[ptr_r] <= start_nxt;
      end
      if (fill_we) begin
        fill_r[ptr_r] <= fill_nxt;
      end
      if (cap_we) begin
        cap_r[ptr_r] <= cap_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    base_r     <= base_nxt;
    idx_r      <= idx_nxt;
    mode_r     <= mode_nxt;
    sel_r      <= sel_nxt;
    val_r      <= val_nxt;
    res_val_r  <= res_val_nxt;
    res_st_r   <= res_st_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

FILE: tb/testbench.sv
module testbench;
  import sbems_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NSTK  = 3;
  localparam int ICAP  = 8;
  localparam int DEPTH = NSTK * ICAP;
  localparam int CYCLE_LIMIT = 400000;
  localparam logic [1:0] MODE_BAD = 2'd3;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  sbems_in_t  in_data;
  logic       out_valid;
  logic       out_stall;
  sbems_out_t out_data;

  shared_buffer_elastic_multi_stack #(
    .NUM_STACKS(NSTK),
    .INIT_CAPACITY(ICAP)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data)
  );

  // Shadow state of the shared ring and per-stack bookkeeping.
  logic [31:0] ring_word [DEPTH];
  int unsigned stk_base [NSTK];
  int unsigned stk_fill [NSTK];
  int unsigned stk_cap [NSTK];

  sbems_in_t  pending_items[$];
  sbems_out_t expected_results[$];

  int  errors;
  int  n_accepted;
  int  n_checked;
  int  n_full;
  int  n_empty;
  int  n_grow;
  bit  hold_off_req;
  bit  in_taken;
  longint cycles;

  function automatic int unsigned ring_idx(int unsigned i);
    return i % DEPTH;
  endfunction

  // Append one item to the stimulus queue.
  function automatic void queue_item(sbems_in_t it);
    pending_items = {pending_items, it};
  endfunction

  // Shift one stack up by one slot; its lowest slot is cleared.
  function automatic void shift_stack_up(int unsigned s);
    int unsigned b;
    b = stk_base[s];
    for (int unsigned i = stk_cap[s]; i > 1; i--)
      ring_word[ring_idx(b + i - 1)] = ring_word[ring_idx(b + i - 2)];
    ring_word[ring_idx(b)] = '0;
    stk_base[s] = ring_idx(b + 1);
  endfunction

  // Borrow one slot for stack s from the next stack in ring order with room.
  function automatic void borrow_slot(int unsigned s);
    int unsigned j;
    int unsigned n;
    int unsigned k;
    j = (s + 1) % NSTK;
    n = 0;
    while (stk_fill[j] >= stk_cap[j] && n < NSTK) begin
      j = (j + 1) % NSTK;
      n++;
    end
    k = j;
    while (k != s) begin
      if (k != j) stk_cap[k]++;
      shift_stack_up(k);
      stk_cap[k]--;
      k = (k + NSTK - 1) % NSTK;
    end
    stk_cap[s]++;
  endfunction

  function automatic sbems_out_t stack_op_result(sbems_in_t it);
    sbems_out_t r;
    int unsigned total;
    int unsigned t;
    r.read_value = '0;
    r.status     = STAT_OK;
    if (it.stack_sel < NSTK) begin
      if (it.mode == MODE_PUSH) begin
        total = 0;
        for (int k = 0; k < NSTK; k++) total += stk_fill[k];
        if (total >= DEPTH) begin
          r.status = STAT_FULL;
        end else begin
          if (stk_fill[it.stack_sel] >= stk_cap[it.stack_sel]) begin
            borrow_slot(it.stack_sel);
            n_grow++;
          end
          stk_fill[it.stack_sel]++;
          t = ring_idx(stk_base[it.stack_sel] + stk_fill[it.stack_sel] + DEPTH - 1);
          ring_word[t] = it.push_value;
        end
      end else if (it.mode == MODE_POP || it.mode == MODE_PEEK) begin
        if (stk_fill[it.stack_sel] == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          t = ring_idx(stk_base[it.stack_sel] + stk_fill[it.stack_sel] + DEPTH - 1);
          r.read_value = ring_word[t];
          if (it.mode == MODE_POP) begin
            ring_word[t] = '0;
            stk_fill[it.stack_sel]--;
          end
        end
      end
    end
    return r;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  function automatic sbems_in_t make_item(logic [1:0] m, logic [1:0] s, logic [31:0] v);
    sbems_in_t it;
    it.mode       = m;
    it.stack_sel  = s;
    it.push_value = v;
    return it;
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Driver: present the next pending item; hold it until it is taken.
  int drv_gap;
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      drv_gap  <= 0;
    end else if (in_valid && !in_taken) begin
      // hold the waiting item unchanged
    end else if (drv_gap > 0) begin
      in_valid <= 1'b0;
      drv_gap  <= drv_gap - 1;
    end else if (pending_items.size() > 0) begin
      in_data  <= pending_items.pop_front();
      in_valid <= 1'b1;
      drv_gap  <= gap_len();
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Receiver stall: random gaps, plus one long hold-off on request.
  int rcv_gap;
  int hold_cnt;
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      rcv_gap   <= 0;
      hold_cnt  <= 0;
    end else if (hold_off_req && hold_cnt < 300) begin
      out_stall <= 1'b1;
      hold_cnt  <= hold_cnt + 1;
    end else if (rcv_gap > 0) begin
      out_stall <= 1'b1;
      rcv_gap   <= rcv_gap - 1;
    end else begin
      out_stall <= 1'b0;
      rcv_gap   <= gap_len();
    end
  end

  // Input monitor: predict at the moment an item is accepted.
  always @(posedge clk) begin
    in_taken <= rst_n && in_valid && !in_stall;
    if (rst_n && in_valid && !in_stall) begin
      expected_results = {expected_results, stack_op_result(in_data)};
      n_accepted++;
    end
  end

  // Result monitor: compare against the oldest expectation.
  always @(posedge clk) begin
    sbems_out_t exp_r;
    cycles <= cycles + 1;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t unexpected result read_value=%0d status=%0d", $time,
                 out_data.read_value, out_data.status);
        errors++;
      end else begin
        exp_r = expected_results.pop_front();
        n_checked++;
        if (exp_r.status == STAT_FULL) n_full++;
        if (exp_r.status == STAT_EMPTY) n_empty++;
        if (out_data.read_value !== exp_r.read_value) begin
          $display("%0t read_value mismatch: expected %0d actual %0d", $time,
                   exp_r.read_value, out_data.read_value);
          errors++;
        end
        if (out_data.status !== exp_r.status) begin
          $display("%0t status mismatch: expected %0d actual %0d", $time,
                   exp_r.status, out_data.status);
          errors++;
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("TB_ERROR");
      $finish;
    end
  end

  initial begin
    logic [1:0] m;
    logic [1:0] s;
    int p;
    int burst;
    errors = 0; n_accepted = 0; n_checked = 0;
    n_full = 0; n_empty = 0; n_grow = 0;
    cycles = 0; hold_off_req = 0; in_taken = 0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    out_stall = 1'b0;
    in_data = '0;
    for (int k = 0; k < DEPTH; k++) ring_word[k] = '0;
    for (int k = 0; k < NSTK; k++) begin
      stk_base[k] = k * ICAP;
      stk_fill[k] = 0;
      stk_cap[k]  = ICAP;
    end
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: empty pop/peek, extreme values, bad mode and stack.
    queue_item(make_item(MODE_POP, 2'd0, 32'h0));
    queue_item(make_item(MODE_PEEK, 2'd2, 32'h0));
    queue_item(make_item(MODE_PUSH, 2'd1, 32'h8000_0000));
    queue_item(make_item(MODE_PUSH, 2'd1, 32'h7FFF_FFFF));
    queue_item(make_item(MODE_PEEK, 2'd1, 32'h0));
    queue_item(make_item(MODE_POP, 2'd1, 32'hFFFF_FFFF));
    queue_item(make_item(MODE_POP, 2'd1, 32'h0));
    queue_item(make_item(MODE_POP, 2'd1, 32'h0));
    queue_item(make_item(MODE_BAD, 2'd0, 32'hFFFF_FFFF));
    queue_item(make_item(MODE_PUSH, 2'd3, 32'h1234_5678));
    queue_item(make_item(MODE_POP, 2'd3, 32'h0));
    // Fill the whole ring through stack 2 so that growth wraps past index 0,
    // then one push more to hit the all-full case.
    for (int i = 0; i < DEPTH; i++)
      queue_item(make_item(MODE_PUSH, 2'd2, $urandom));
    queue_item(make_item(MODE_PUSH, 2'd0, 32'hA5A5_A5A5));

    // Long receiver hold-off while the sender keeps offering items.
    wait (pending_items.size() == 0);
    hold_off_req = 1;
    for (int i = 0; i < DEPTH + 4; i++)
      queue_item(make_item(MODE_POP, 2'd2, $urandom));
    wait (hold_cnt >= 300);
    hold_off_req = 0;

    // Random: bursts of pushes/pops on varying stacks, some noise.
    while (n_accepted + pending_items.size() < 540) begin
      burst = $urandom_range(30, 1);
      p = $urandom_range(99);
      for (int i = 0; i < burst; i++) begin
        s = 2'($urandom_range(NSTK - 1));
        if (p < 45) m = ($urandom_range(9) < 8) ? MODE_PUSH : MODE_PEEK;
        else if (p < 85) m = ($urandom_range(9) < 7) ? MODE_POP : MODE_PEEK;
        else begin
          m = 2'($urandom_range(3));
          s = 2'($urandom_range(3));
        end
        queue_item(make_item(m, s, $urandom));
      end
      wait (pending_items.size() < 4);
    end
    wait (pending_items.size() == 0);
    wait (!in_valid && expected_results.size() == 0);
    repeat (100) @(posedge clk);

    $display("%0d items accepted, %0d results checked", n_accepted, n_checked);
    $display("%0d full, %0d empty, %0d stack expansions", n_full, n_empty, n_grow);
    if (errors == 0 && expected_results.size() == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end
endmodule

FILE: filelist.f
hdl/sbems_pkg.sv
hdl/sbems_ram.sv
hdl/shared_buffer_elastic_multi_stack.sv
tb/testbench.sv
